[rtl/sha_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 stream hasher
// Command bundle from controller to datapath, byte source codes, round
// constants and initial hash values.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int WORD_W  = 32;
    localparam int LEN_W   = 61;
    localparam int ROUNDS  = 64;

    // byte source into the block window
    localparam logic [1:0] BSEL_DATA = 2'd0;
    localparam logic [1:0] BSEL_PAD  = 2'd1;
    localparam logic [1:0] BSEL_ZERO = 2'd2;
    localparam logic [1:0] BSEL_LEN  = 2'd3;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;

    typedef struct packed {
        logic       shift_en;
        logic [1:0] byte_sel;
        logic [2:0] len_idx;
        logic       load_work;
        logic       round_en;
        logic [5:0] round_idx;
        logic       add_chain;
        logic       init_msg;
        logic       len_inc;
        logic       out_load;
        logic [2:0] out_idx;
    } cmd_t;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage
`default_nettype wire

[rtl/sha_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha_dp: SHA-256 datapath
// Byte window that doubles as the message schedule, one round per cycle,
// chaining words, message length and the digest output register.
// ----------------------------------------------------------------------------
module sha_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sha_pkg::cmd_t cmd,
    input  wire logic [7:0]    data_byte,
    output logic [31:0]        digest_word
);
    import sha_pkg::*;

    logic [31:0]      win_reg   [16];
    logic [31:0]      win_next  [16];
    logic [31:0]      work_reg  [8];
    logic [31:0]      work_next [8];
    logic [31:0]      chain_reg [8];
    logic [31:0]      chain_next[8];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [31:0]      dout_reg;
    logic [31:0]      dout_next;

    logic [7:0]       byte_in;
    logic [63:0]      bit_len;
    logic [5:0]       len_sh;
    logic [31:0]      s0, s1, sg0, sg1, ch, maj, t1, t2, w_new;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

    // length bytes go out most significant first
    assign bit_len = {len_reg, 3'b000};
    assign len_sh  = {3'd7 - cmd.len_idx, 3'b000};

    always_comb
    begin
        case (cmd.byte_sel)
            BSEL_DATA: byte_in = data_byte;
            BSEL_PAD:  byte_in = PAD_BYTE;
            BSEL_ZERO: byte_in = 8'h00;
            BSEL_LEN:  byte_in = bit_len[len_sh +: 8];
            default:   byte_in = 8'h00;
        endcase
    end

    // round function
    assign s1  = ror(work_reg[4], 6) ^ ror(work_reg[4], 11) ^ ror(work_reg[4], 25);
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign t1  = work_reg[7] + s1 + ch + SHA_K[cmd.round_idx] + win_reg[0];
    assign s0  = ror(work_reg[0], 2) ^ ror(work_reg[0], 13) ^ ror(work_reg[0], 22);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t2  = s0 + maj;

    // schedule expansion, W[t+16] from the sliding window
    assign sg0   = ror(win_reg[1], 7) ^ ror(win_reg[1], 18) ^ (win_reg[1] >> 3);
    assign sg1   = ror(win_reg[14], 17) ^ ror(win_reg[14], 19) ^ (win_reg[14] >> 10);
    assign w_new = win_reg[0] + sg0 + win_reg[9] + sg1;

    always_comb
    begin
        win_next   = win_reg;
        work_next  = work_reg;
        chain_next = chain_reg;
        len_next   = len_reg;
        dout_next  = dout_reg;

        if (cmd.shift_en)
        begin
            for (int i = 0; i < 15; i++)
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            win_next[15] = {win_reg[15][23:0], byte_in};
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
                win_next[i] = win_reg[i+1];
            win_next[15] = w_new;
        end

        if (cmd.load_work)
            work_next = chain_reg;
        else if (cmd.round_en)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end

        if (cmd.init_msg)
            chain_next = SHA_IV;
        else if (cmd.add_chain)
            for (int i = 0; i < 8; i++)
                chain_next[i] = chain_reg[i] + work_reg[i];

        if (cmd.init_msg)
            len_next = '0;
        else if (cmd.len_inc)
            len_next = len_reg + LEN_W'(1);

        if (cmd.out_load)
            dout_next = chain_reg[cmd.out_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= SHA_IV;
            len_reg   <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
        dout_reg <= dout_next;
    end

    assign digest_word = dout_reg;

endmodule
`default_nettype wire

[rtl/sha_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha_ctrl: SHA-256 sequencer
// Tracks block fill, drives padding, round and digest output steps, and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic       kind,
    output logic            item_stall,
    output logic            digest_valid,
    input  wire logic       digest_stall,
    output logic [2:0]      word_index,
    output logic            last_word,
    output sha_pkg::cmd_t   cmd
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD80 = 3'd1;
    localparam logic [2:0] S_PADZ  = 3'd2;
    localparam logic [2:0] S_PLEN  = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] after_reg, after_next;
    logic [5:0] fill_reg,  fill_next;
    logic [5:0] cnt_reg,   cnt_next;
    logic       ovld_reg,  ovld_next;
    logic [2:0] oidx_reg,  oidx_next;
    logic       olast_reg, olast_next;
    logic       can_load;
    logic       blk_full;

    assign can_load = !ovld_reg || !digest_stall;
    assign blk_full = (fill_reg == 6'd63);

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        ovld_next  = ovld_reg && digest_stall;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (kind)
                        state_next = S_PAD80;
                    else
                    begin
                        cmd.shift_en = 1'b1;
                        cmd.byte_sel = BSEL_DATA;
                        cmd.len_inc  = 1'b1;
                        fill_next    = fill_reg + 6'd1;
                        if (blk_full)
                        begin
                            cmd.load_work = 1'b1;
                            cnt_next      = '0;
                            after_next    = S_IDLE;
                            state_next    = S_ROUND;
                        end
                    end
                end
            end
            S_PAD80:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = BSEL_PAD;
                fill_next    = fill_reg + 6'd1;
                state_next   = S_PADZ;
                if (blk_full)
                begin
                    cmd.load_work = 1'b1;
                    cnt_next      = '0;
                    after_next    = S_PADZ;
                    state_next    = S_ROUND;
                end
            end
            S_PADZ:
            begin
                if (fill_reg == LEN_POS)
                begin
                    cnt_next   = '0;
                    state_next = S_PLEN;
                end
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = BSEL_ZERO;
                    fill_next    = fill_reg + 6'd1;
                    if (blk_full)
                    begin
                        cmd.load_work = 1'b1;
                        cnt_next      = '0;
                        after_next    = S_PADZ;
                        state_next    = S_ROUND;
                    end
                end
            end
            S_PLEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = BSEL_LEN;
                cmd.len_idx  = cnt_reg[2:0];
                fill_next    = fill_reg + 6'd1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    cmd.load_work = 1'b1;
                    cnt_next      = '0;
                    after_next    = S_EMIT;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round_en  = 1'b1;
                cmd.round_idx = cnt_reg;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_chain = 1'b1;
                cnt_next      = '0;
                state_next    = after_reg;
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_idx  = cnt_reg[2:0];
                    ovld_next    = 1'b1;
                    oidx_next    = cnt_reg[2:0];
                    olast_next   = (cnt_reg[2:0] == 3'd7);
                    cnt_next     = cnt_reg + 6'd1;
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        cmd.init_msg = 1'b1;
                        cnt_next     = '0;
                        fill_next    = '0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= S_IDLE;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            ovld_reg  <= 1'b0;
            oidx_reg  <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            ovld_reg  <= ovld_next;
            oidx_reg  <= oidx_next;
            olast_reg <= olast_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign digest_valid = ovld_reg;
    assign word_index   = oidx_reg;
    assign last_word    = olast_reg;

endmodule
`default_nettype wire

[rtl/sha256_stream_hasher.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream
// Input channel (item_valid/item_stall): kind 0 appends data_byte to the
// message, kind 1 closes the message. Output channel (digest_valid/
// digest_stall): eight digest_word beats, word_index 0 (most significant)
// to 7, last_word set on the eighth beat.
// Flow: append beats are accepted back to back. The beat that fills a
// 64-byte block starts compression: the rounds, then a chaining add, with
// the input stalled, one round per cycle through a single round unit.
// A finish beat pads byte-serially (one padding byte per cycle up to the
// length field, then a step that detects it, then the 8 length bytes),
// compresses one or two blocks, then issues one digest beat per cycle
// while the output register is free or its pending beat is taken.
// The output register holds a beat while digest_stall is high; digest
// words wait in the chaining registers, so the stall only delays them.
// The input reopens on the cycle after the last word is loaded, with the
// hash state back at its initial values, while that word may still wait.
// Reset: hash state returns to the initial values, byte count to zero, no
// beat pending. Block contents are not cleared; shifted-in bytes overwrite them.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        kind,
    input  wire logic [7:0]  data_byte,
    output logic             digest_valid,
    input  wire logic        digest_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sha_pkg::*;

    cmd_t cmd;

    // sequencer: fill tracking, padding, round count, output handshake
    sha_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .kind         (kind),
        .item_stall   (item_stall),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .word_index   (word_index),
        .last_word    (last_word),
        .cmd          (cmd)
    );

    // block window / schedule, round unit, chaining words, digest register
    sha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .digest_word (digest_word)
    );

    // a finish beat always closes the input for padding
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && kind) |=> item_stall)
        else $error("input open right after finish beat");

    // words 0..6 are followed directly by the next word
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && !last_word) |=> digest_valid)
        else $error("gap inside digest burst");

    // while a non-final word is pending the input stays closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !last_word) |-> item_stall)
        else $error("input open during digest burst");

    // last flag marks exactly word seven
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    // a new command never mixes a byte shift with a round step
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift_en && cmd.round_en))
        else $error("shift and round issued together");

endmodule
`default_nettype wire
